// ===== rtl/hmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// hmmd_pkg
// Shared types, codes and helpers for the handheld memory map decoder.
// ----------------------------------------------------------------------------
package hmmd_pkg;

    // Store sizes
    localparam int unsigned VBANK_SIZE       = 8192;
    localparam int unsigned WBANK_SIZE       = 4096;
    localparam int unsigned HIGH_DEPTH       = 128;
    localparam int unsigned VIDEO_BANKS_DEF  = 2;
    localparam int unsigned WORK_BANKS_DEF   = 8;

    // Map boundaries
    localparam logic [15:0] A_VRAM     = 16'h8000;
    localparam logic [15:0] A_CRAM     = 16'hA000;
    localparam logic [15:0] A_WRAM     = 16'hC000;
    localparam logic [15:0] A_SPRITE   = 16'hFE00;
    localparam logic [15:0] A_GAP      = 16'hFEA0;
    localparam logic [15:0] A_IO       = 16'hFF00;
    localparam logic [15:0] A_HRAM     = 16'hFF80;
    localparam logic [15:0] A_IE       = 16'hFFFF;
    localparam logic [15:0] A_BOOT_END = 16'h0100;
    localparam logic [15:0] A_BOOT_CLO = 16'h0200;
    localparam logic [15:0] A_BOOT_CHI = 16'h0FFF;
    localparam logic [7:0]  UNMAPPED_BYTE = 8'hFF;

    // Target codes
    typedef logic [2:0] t_target;
    localparam t_target TGT_INTERNAL = 3'd0;
    localparam t_target TGT_BOOT     = 3'd1;
    localparam t_target TGT_CROM     = 3'd2;
    localparam t_target TGT_CRAM     = 3'd3;
    localparam t_target TGT_SPRITE   = 3'd4;
    localparam t_target TGT_IO       = 3'd5;
    localparam t_target TGT_NONE     = 3'd6;

    // Internal store select
    typedef logic [1:0] t_store;
    localparam t_store ST_NONE = 2'd0;
    localparam t_store ST_VRAM = 2'd1;
    localparam t_store ST_WRAM = 2'd2;
    localparam t_store ST_HRAM = 2'd3;

    // Config register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_BOOT_OVERLAY = 2'd0;
    localparam t_cfg_index CFG_COLOR_MODE   = 2'd1;
    localparam t_cfg_index CFG_VIDEO_BANK   = 2'd2;
    localparam t_cfg_index CFG_WORK_BANK    = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_data;
        t_target     target;
        logic [15:0] ext_offset;
        logic        ext_write;
        logic [7:0]  ext_data;
    } t_out;

    // Decoded word passed from the front to the back
    typedef struct packed {
        t_store      store;
        logic        wr;
        t_target     target;
        logic [15:0] ext_offset;
        logic        ext_write;
        logic [7:0]  fixed_data;
        logic [15:0] mem_addr;
        logic [7:0]  data;
    } t_item;

    // Bank number wrapped into the bank count (count is 2..8)
    function automatic logic [2:0] wrap_bank(input logic [2:0] b, input int unsigned n);
        logic [2:0] v;
        v = b;
        for (int i = 0; i < 3; i++) begin
            if (int'(v) >= int'(n)) begin
                v = v - 3'(n);
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/hmmd_front.sv =====
// ----------------------------------------------------------------------------
// hmmd_front
// Holds the config registers, accepts bus words and decodes the address map.
// ----------------------------------------------------------------------------
module hmmd_front #(
    parameter int unsigned VIDEO_BANKS = hmmd_pkg::VIDEO_BANKS_DEF,
    parameter int unsigned WORK_BANKS  = hmmd_pkg::WORK_BANKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  hmmd_pkg::t_cfg_index  i_cfg_index,
    input  logic [2:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  hmmd_pkg::t_in         i_in_data,
    input  logic                  i_q_full,
    input  logic                  i_busy,
    output logic                  o_push,
    output hmmd_pkg::t_item       o_item
);
    import hmmd_pkg::*;

    logic       r_boot_overlay;
    logic       r_color_mode;
    logic       r_video_bank;
    logic [2:0] r_work_bank;
    logic [2:0] vb;
    logic [2:0] wb;
    logic [15:0] a;
    logic       wr;
    logic       boot_hit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full && !i_busy;
    assign o_push      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_overlay <= 1'b1;
            r_color_mode   <= 1'b0;
            r_video_bank   <= 1'b0;
            r_work_bank    <= 3'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BOOT_OVERLAY: r_boot_overlay <= i_cfg_data[0];
                CFG_COLOR_MODE:   r_color_mode   <= i_cfg_data[0];
                CFG_VIDEO_BANK:   r_video_bank   <= i_cfg_data[0];
                CFG_WORK_BANK:    r_work_bank    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign a  = i_in_data.address;
    assign wr = i_in_data.opcode;
    assign vb = wrap_bank({2'b00, r_video_bank}, VIDEO_BANKS);
    assign wb = wrap_bank(r_work_bank, WORK_BANKS);
    assign boot_hit = !wr && r_boot_overlay &&
                      (a < A_BOOT_END || (r_color_mode && a >= A_BOOT_CLO && a <= A_BOOT_CHI));

    always_comb begin
        o_item            = '0;
        o_item.wr         = wr;
        o_item.data       = i_in_data.write_data;
        o_item.store      = ST_NONE;
        o_item.target     = TGT_INTERNAL;
        if (a < A_VRAM) begin
            o_item.target     = boot_hit ? TGT_BOOT : TGT_CROM;
            o_item.ext_offset = a;
        end else if (a < A_CRAM) begin
            o_item.store    = ST_VRAM;
            o_item.mem_addr = {vb, a[12:0]};
        end else if (a < A_WRAM) begin
            o_item.target     = TGT_CRAM;
            o_item.ext_offset = a;
        end else if (a < A_SPRITE) begin
            // Echo rides along: bit 12 picks bank 0 or the selected bank
            o_item.store    = ST_WRAM;
            o_item.mem_addr = a[12] ? {1'b0, wb, a[11:0]} : {4'b0000, a[11:0]};
        end else if (a < A_GAP) begin
            o_item.target     = TGT_SPRITE;
            o_item.ext_offset = {8'h00, a[7:0]};
        end else if (a < A_IO) begin
            o_item.target     = TGT_NONE;
            o_item.fixed_data = wr ? 8'h00 : UNMAPPED_BYTE;
        end else if (a < A_HRAM || a == A_IE) begin
            o_item.target     = TGT_IO;
            o_item.ext_offset = {8'h00, a[7:0]};
        end else begin
            o_item.store    = ST_HRAM;
            o_item.mem_addr = {9'd0, a[6:0]};
        end
        o_item.ext_write = wr && o_item.target != TGT_INTERNAL && o_item.target != TGT_NONE;
    end

endmodule

// ===== rtl/hmmd_queue.sv =====
// ----------------------------------------------------------------------------
// hmmd_queue
// Two-entry queue of decoded words between the front and the back.
// ----------------------------------------------------------------------------
module hmmd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hmmd_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output hmmd_pkg::t_item  o_item
);
    import hmmd_pkg::*;

    t_item      r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_item  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/hmmd_back.sv =====
// ----------------------------------------------------------------------------
// hmmd_back
// Owns video, work and high RAM, clears them after reset, carries out each
// decoded word and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module hmmd_back #(
    parameter int unsigned VIDEO_BANKS = hmmd_pkg::VIDEO_BANKS_DEF,
    parameter int unsigned WORK_BANKS  = hmmd_pkg::WORK_BANKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  hmmd_pkg::t_item  i_q_item,
    output logic             o_pop,
    output logic             o_busy,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hmmd_pkg::t_out   o_out_data
);
    import hmmd_pkg::*;

    localparam int unsigned VDEPTH    = VIDEO_BANKS * VBANK_SIZE;
    localparam int unsigned WDEPTH    = WORK_BANKS * WBANK_SIZE;
    localparam int unsigned VA_W      = $clog2(VDEPTH);
    localparam int unsigned WA_W      = $clog2(WDEPTH);
    localparam int unsigned HA_W      = $clog2(HIGH_DEPTH);
    localparam int unsigned CLR_DEPTH = (VDEPTH > WDEPTH) ? VDEPTH : WDEPTH;
    localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

    logic [7:0] r_vram [VDEPTH];
    logic [7:0] r_wram [WDEPTH];
    logic [7:0] r_hram [HIGH_DEPTH];

    logic [CLR_W-1:0] r_clr_cnt;
    logic             r_clearing;
    logic             r_s_valid;
    t_item            r_s_item;
    logic [7:0]       r_vq;
    logic [7:0]       r_wq;
    logic [7:0]       r_hq;

    logic             clr_v;
    logic             clr_w;
    logic             clr_h;
    logic [VA_W-1:0]  v_idx;
    logic [WA_W-1:0]  w_idx;
    logic [HA_W-1:0]  h_idx;
    logic             do_wr;
    logic [7:0]       rd;

    assign o_busy = r_clearing;
    assign o_pop  = i_q_valid && !r_clearing && (!r_s_valid || i_out_ready);
    assign do_wr  = o_pop && i_q_item.wr;

    assign clr_v = r_clearing && ({1'b0, r_clr_cnt} < (CLR_W+1)'(VDEPTH));
    assign clr_w = r_clearing && ({1'b0, r_clr_cnt} < (CLR_W+1)'(WDEPTH));
    assign clr_h = r_clearing && ({1'b0, r_clr_cnt} < (CLR_W+1)'(HIGH_DEPTH));

    assign v_idx = clr_v ? r_clr_cnt[VA_W-1:0] : i_q_item.mem_addr[VA_W-1:0];
    assign w_idx = clr_w ? r_clr_cnt[WA_W-1:0] : i_q_item.mem_addr[WA_W-1:0];
    assign h_idx = clr_h ? r_clr_cnt[HA_W-1:0] : i_q_item.mem_addr[HA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (clr_v || (do_wr && i_q_item.store == ST_VRAM)) begin
            r_vram[v_idx] <= clr_v ? 8'h00 : i_q_item.data;
        end
        if (o_pop) begin
            r_vq <= r_vram[v_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_w || (do_wr && i_q_item.store == ST_WRAM)) begin
            r_wram[w_idx] <= clr_w ? 8'h00 : i_q_item.data;
        end
        if (o_pop) begin
            r_wq <= r_wram[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_h || (do_wr && i_q_item.store == ST_HRAM)) begin
            r_hram[h_idx] <= clr_h ? 8'h00 : i_q_item.data;
        end
        if (o_pop) begin
            r_hq <= r_hram[h_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s_item <= i_q_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clearing <= 1'b1;
            r_s_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (o_pop) begin
                r_s_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (r_s_item.store)
            ST_VRAM: rd = r_vq;
            ST_WRAM: rd = r_wq;
            ST_HRAM: rd = r_hq;
            default: rd = r_s_item.fixed_data;
        endcase
        if (r_s_item.wr) begin
            rd = 8'h00;
        end
    end

    assign o_out_valid           = r_s_valid;
    assign o_out_data.read_data  = rd;
    assign o_out_data.target     = r_s_item.target;
    assign o_out_data.ext_offset = r_s_item.ext_offset;
    assign o_out_data.ext_write  = r_s_item.ext_write;
    assign o_out_data.ext_data   = r_s_item.ext_write ? r_s_item.data : 8'h00;

endmodule

// ===== rtl/handheld_memory_map_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_unit
// Byte bus decoder for the handheld memory map with internal video, work and
// high RAM.
// ----------------------------------------------------------------------------
// Path: an accepted bus word is queued, then popped into the result register,
// which holds it until taken; each internal RAM serves one access a cycle.
// Throughput: one word per cycle unless the queue is full or RAMs are clearing.
// Reset: config registers take their reset values; the RAMs are then zeroed by
// a clearing pass over max(VIDEO_BANKS*8192, WORK_BANKS*4096) addresses (32768
// by default) during which no bus word is accepted; config writes are taken.
module handheld_memory_map_decoder_unit #(
    parameter int unsigned VIDEO_BANKS = hmmd_pkg::VIDEO_BANKS_DEF,
    parameter int unsigned WORK_BANKS  = hmmd_pkg::WORK_BANKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  hmmd_pkg::t_cfg_index  i_cfg_index,
    input  logic [2:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  hmmd_pkg::t_in         i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output hmmd_pkg::t_out        o_out_data
);
    import hmmd_pkg::*;

    logic  push;
    t_item push_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  pop;
    logic  busy;

    hmmd_front #(
        .VIDEO_BANKS (VIDEO_BANKS),
        .WORK_BANKS  (WORK_BANKS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .i_busy      (busy),
        .o_push      (push),
        .o_item      (push_item)
    );

    hmmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    hmmd_back #(
        .VIDEO_BANKS (VIDEO_BANKS),
        .WORK_BANKS  (WORK_BANKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/sv/handheld_memory_map_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_unit_tb
// Self-checking bench for the memory map decoder. A short table of bus words
// covers the map edges, the boot overlay, the echo and gap regions and bank
// selection. It is followed by random phases, each under its own setting of
// the map registers. Every result word is checked field by field against its
// table entry or an in-bench model of the map and its RAMs. The bench throttles
// both handshakes and stalls the result side for long stretches.
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder_unit_tb;
    import hmmd_pkg::*;

    localparam int unsigned VIDEO_BANKS = VIDEO_BANKS_DEF;
    localparam int unsigned WORK_BANKS  = WORK_BANKS_DEF;
    localparam logic        OP_READ     = 1'b0;
    localparam logic        OP_WRITE    = 1'b1;
    localparam int          PHASES      = 8;
    localparam int          PHASE_WORDS = 100;
    localparam int          HOLD_CYCLES = 400;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = CFG_BOOT_OVERLAY;
    logic [2:0] i_cfg_data  = 3'd0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in        i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out_data;

    handheld_memory_map_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Model of the map registers and RAMs
    logic       map_boot  = 1'b1;
    logic       map_color = 1'b0;
    logic       map_vbank = 1'b0;
    logic [2:0] map_wbank = 3'd1;
    logic [7:0] vram_image [VIDEO_BANKS * VBANK_SIZE];
    logic [7:0] wram_image [WORK_BANKS * WBANK_SIZE];
    logic [7:0] hram_image [HIGH_DEPTH];

    t_out pending_results[$];
    int   error_count  = 0;
    int   results_seen = 0;
    int   burst_left   = 0;

    typedef struct packed {
        logic       is_cfg;
        t_cfg_index cfg_index;
        logic [2:0] cfg_value;
        t_in        word;
        logic       typed;
        t_out       want;
    } t_stim_row;

    t_stim_row directed_rows[$];

    function automatic t_out outcome(logic [7:0] rd, t_target tgt, logic [15:0] off,
                                     int ew, logic [7:0] ed);
        t_out r;
        r.read_data  = rd;
        r.target     = tgt;
        r.ext_offset = off;
        r.ext_write  = (ew != 0);
        r.ext_data   = ed;
        return r;
    endfunction

    function automatic void add_word(logic op, logic [15:0] addr, logic [7:0] data,
                                     int typed, t_out want);
        t_stim_row row;
        row            = '0;
        row.word       = '{opcode: op, address: addr, write_data: data};
        row.typed      = (typed != 0);
        row.want       = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(t_cfg_index idx, logic [2:0] value);
        t_stim_row row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.cfg_index = idx;
        row.cfg_value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void apply_register(t_cfg_index idx, logic [2:0] value);
        case (idx)
            CFG_BOOT_OVERLAY: map_boot  = value[0];
            CFG_COLOR_MODE:   map_color = value[0];
            CFG_VIDEO_BANK:   map_vbank = value[0];
            CFG_WORK_BANK:    map_wbank = value;
            default: ;
        endcase
    endfunction

    // Decode one bus word, update the RAM images and return its result word
    function automatic t_out decode_access(t_in w);
        t_out        r;
        t_store      st;
        int unsigned idx;
        logic [15:0] a;
        r   = '0;
        st  = ST_NONE;
        idx = 0;
        a   = w.address;
        if (a < 16'h8000) begin
            r.target = TGT_CROM;
            if (w.opcode == OP_READ && map_boot &&
                (a < 16'h0100 || (map_color && a >= 16'h0200 && a <= 16'h0FFF))) begin
                r.target = TGT_BOOT;
            end
            r.ext_offset = a;
        end else if (a < 16'hA000) begin
            st  = ST_VRAM;
            idx = (int'(map_vbank) % VIDEO_BANKS) * VBANK_SIZE + int'(a[12:0]);
        end else if (a < 16'hC000) begin
            r.target     = TGT_CRAM;
            r.ext_offset = a;
        end else if (a < 16'hFE00) begin
            // Echo folds onto C000-DFFF through bit 12
            st  = ST_WRAM;
            idx = a[12] ? (int'(map_wbank) % WORK_BANKS) * WBANK_SIZE + int'(a[11:0])
                        : int'(a[11:0]);
        end else if (a < 16'hFEA0) begin
            r.target     = TGT_SPRITE;
            r.ext_offset = {8'h00, a[7:0]};
        end else if (a < 16'hFF00) begin
            r.target = TGT_NONE;
            if (w.opcode == OP_READ) begin
                r.read_data = UNMAPPED_BYTE;
            end
        end else if (a < 16'hFF80 || a == 16'hFFFF) begin
            r.target     = TGT_IO;
            r.ext_offset = {8'h00, a[7:0]};
        end else begin
            st  = ST_HRAM;
            idx = int'(a[6:0]);
        end
        case (st)
            ST_VRAM: if (w.opcode == OP_WRITE) vram_image[idx] = w.write_data;
                     else r.read_data = vram_image[idx];
            ST_WRAM: if (w.opcode == OP_WRITE) wram_image[idx] = w.write_data;
                     else r.read_data = wram_image[idx];
            ST_HRAM: if (w.opcode == OP_WRITE) hram_image[idx] = w.write_data;
                     else r.read_data = hram_image[idx];
            default: ;
        endcase
        if (r.target != TGT_INTERNAL && r.target != TGT_NONE && w.opcode == OP_WRITE) begin
            r.ext_write = 1'b1;
            r.ext_data  = w.write_data;
        end
        return r;
    endfunction

    function automatic t_in random_word();
        t_in         w;
        logic [15:0] pick;
        logic [15:0] a;
        // Half the time a small pool per region, so reads land on earlier writes
        pick = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        case ($urandom_range(0, 9))
            0: a = pick & 16'h0FFF;
            1: a = pick & 16'h7FFF;
            2: a = 16'h8000 | (pick & 16'h1FFF);
            3: a = 16'hA000 | (pick & 16'h1FFF);
            4: a = 16'hC000 | (pick & 16'h1FFF) | 16'($urandom_range(0, 1) << 12);
            5: a = $urandom_range(0, 1) ? 16'hE000 + (pick & 16'h0FFF)
                                        : 16'hF000 + (pick % 16'h0E00);
            6: a = 16'hFE00 + 16'($urandom_range(0, 255));
            7: a = 16'hFF00 | ($urandom_range(0, 1) ? (16'h0080 | pick[6:0])
                                                    : 16'($urandom_range(0, 255)));
            default: a = 16'($urandom);
        endcase
        w.opcode     = 1'($urandom_range(0, 1));
        w.address    = a;
        w.write_data = 8'($urandom);
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [35:0] got, logic [35:0] want);
        error_count++;
        $display("mismatch on result %0d: %s got %h want %h",
                 results_seen, what, got, want);
    endtask

    // Result checker
    t_out oldest;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", o_out_data, '0);
            end else begin
                oldest = pending_results.pop_front();
                if (o_out_data.read_data != oldest.read_data)
                    report_mismatch("read_data", 36'(o_out_data.read_data),
                                    36'(oldest.read_data));
                if (o_out_data.target != oldest.target)
                    report_mismatch("target", 36'(o_out_data.target), 36'(oldest.target));
                if (o_out_data.ext_offset != oldest.ext_offset)
                    report_mismatch("ext_offset", 36'(o_out_data.ext_offset),
                                    36'(oldest.ext_offset));
                if (o_out_data.ext_write != oldest.ext_write)
                    report_mismatch("ext_write", 36'(o_out_data.ext_write),
                                    36'(oldest.ext_write));
                if (o_out_data.ext_data != oldest.ext_data)
                    report_mismatch("ext_data", 36'(o_out_data.ext_data),
                                    36'(oldest.ext_data));
            end
            results_seen++;
        end
    end

    // Result side: stall pattern of its own, plus a long hold on request
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   rx_mode     = 0;
    int   rx_mode_left = 0;
    always @(negedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 7) == 0);
                default: i_out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_word(t_in w, logic typed, t_out want);
        t_out predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = decode_access(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Bursts of random length with random gaps between most of them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Drop valid and wait until every result word is back
    task automatic wait_quiet(int tail);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [2:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_map_config(logic [2:0] boot, logic [2:0] color,
                                  logic [2:0] vbank, logic [2:0] wbank);
        wait_quiet(4);
        write_register(CFG_BOOT_OVERLAY, boot);
        write_register(CFG_COLOR_MODE, color);
        write_register(CFG_VIDEO_BANK, vbank);
        write_register(CFG_WORK_BANK, wbank);
    endtask

    initial begin
        #600000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        foreach (vram_image[k]) vram_image[k] = 8'h00;
        foreach (wram_image[k]) wram_image[k] = 8'h00;
        foreach (hram_image[k]) hram_image[k] = 8'h00;

        // Reset settings: overlay on, color off, video bank 0, work bank 1
        add_word(OP_READ,  16'h0000, 8'h00, 1, outcome(8'h00, TGT_BOOT, 16'h0000, 0, 8'h00));
        add_word(OP_READ,  16'h00FF, 8'h00, 1, outcome(8'h00, TGT_BOOT, 16'h00FF, 0, 8'h00));
        add_word(OP_READ,  16'h0100, 8'h00, 1, outcome(8'h00, TGT_CROM, 16'h0100, 0, 8'h00));
        add_word(OP_READ,  16'h0200, 8'h00, 1, outcome(8'h00, TGT_CROM, 16'h0200, 0, 8'h00));
        add_word(OP_WRITE, 16'h0000, 8'hFF, 1, outcome(8'h00, TGT_CROM, 16'h0000, 1, 8'hFF));
        add_word(OP_READ,  16'h8000, 8'h00, 1, outcome(8'h00, TGT_INTERNAL, 16'h0000, 0, 8'h00));
        add_word(OP_WRITE, 16'h9FFF, 8'hA5, 1, outcome(8'h00, TGT_INTERNAL, 16'h0000, 0, 8'h00));
        add_word(OP_READ,  16'h9FFF, 8'h00, 0, '0);
        add_word(OP_WRITE, 16'hBFFF, 8'h5A, 1, outcome(8'h00, TGT_CRAM, 16'hBFFF, 1, 8'h5A));
        add_word(OP_WRITE, 16'hC000, 8'h3C, 1, outcome(8'h00, TGT_INTERNAL, 16'h0000, 0, 8'h00));
        add_word(OP_READ,  16'hE000, 8'h00, 0, '0);
        add_word(OP_WRITE, 16'hFDFF, 8'hC3, 1, outcome(8'h00, TGT_INTERNAL, 16'h0000, 0, 8'h00));
        add_word(OP_READ,  16'hDDFF, 8'h00, 0, '0);
        add_word(OP_WRITE, 16'hFE9F, 8'h11, 1, outcome(8'h00, TGT_SPRITE, 16'h009F, 1, 8'h11));
        add_word(OP_READ,  16'hFEA0, 8'h00, 1, outcome(8'hFF, TGT_NONE, 16'h0000, 0, 8'h00));
        add_word(OP_WRITE, 16'hFEFF, 8'h77, 1, outcome(8'h00, TGT_NONE, 16'h0000, 0, 8'h00));
        add_word(OP_WRITE, 16'hFF7F, 8'h00, 1, outcome(8'h00, TGT_IO, 16'h007F, 1, 8'h00));
        add_word(OP_WRITE, 16'hFFFE, 8'hFF, 1, outcome(8'h00, TGT_INTERNAL, 16'h0000, 0, 8'h00));
        add_word(OP_READ,  16'hFFFE, 8'h00, 0, '0);
        add_word(OP_READ,  16'hFFFF, 8'h00, 1, outcome(8'h00, TGT_IO, 16'h00FF, 0, 8'h00));
        // Color overlay, video bank 1, work bank 0 aliasing C000
        add_cfg(CFG_COLOR_MODE, 3'd1);
        add_cfg(CFG_VIDEO_BANK, 3'd1);
        add_cfg(CFG_WORK_BANK, 3'd0);
        add_word(OP_READ,  16'h0FFF, 8'h00, 0, '0);
        add_word(OP_READ,  16'h1000, 8'h00, 0, '0);
        add_word(OP_READ,  16'hD000, 8'h00, 0, '0);
        add_word(OP_READ,  16'h9FFF, 8'h00, 0, '0);
        add_cfg(CFG_BOOT_OVERLAY, 3'd0);
        add_word(OP_READ,  16'h0000, 8'h00, 0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_quiet(4);
                write_register(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
            end else begin
                pace_sender();
                send_word(directed_rows[i].word, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_map_config(3'd0, 3'd0, 3'd0, 3'd0);
                1: set_map_config(3'd7, 3'd7, 3'd7, 3'd7);
                default: set_map_config(3'($urandom), 3'($urandom),
                                        3'($urandom), 3'($urandom));
            endcase
            // Hold the result side off while words keep coming
            if (ph == 3) hold_toggle = ~hold_toggle;
            repeat (PHASE_WORDS) begin
                pace_sender();
                send_word(random_word(), 1'b0, '0);
            end
        end

        wait_quiet(20);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hmmd_pkg.sv
rtl/hmmd_front.sv
rtl/hmmd_queue.sv
rtl/hmmd_back.sv
rtl/handheld_memory_map_decoder_unit.sv
tb/sv/handheld_memory_map_decoder_unit_tb.sv
